// File: rtl/pcm_pkg.sv
// Shared constants and types for the pedestal and common-mode subtraction block.
`default_nettype none

package pcm_pkg;

  // Default geometry
  localparam int unsigned GROUP_SIZE_DEF        = 37;
  localparam int unsigned GROUPS_PER_MODULE_DEF = 6;
  localparam int unsigned MODULES_DEF           = 6;
  localparam int unsigned ADC_BITS_DEF          = 10;

  // Fixed field widths
  localparam int unsigned CH_W  = 11;  // channel index
  localparam int unsigned VAL_W = 14;  // input value, pedestal Q10.4
  localparam int unsigned OUT_W = 16;  // corrected sample, signed Q.4
  localparam int unsigned SUM_W = 32;  // residual accumulator

  // Saturation limits of the corrected sample
  localparam int CORR_MIN = -16384;
  localparam int CORR_MAX = 32767;

  // Action codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // One result on its way to the output
  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic signed [OUT_W-1:0] corrected;
    logic                    last;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/pedestal_common_mode_subtract.sv
// Top level: pedestal and common-mode subtraction over groups of front-end channels.
`default_nettype none

// Load items (action 0) write a Q10.4 pedestal for a channel. Sample items (action 1)
// are taken one per cycle while no group is ending; each is stored at its slot in the
// group buffer and its residual (sample*16 - pedestal) is added to a running sum.
// The sample at the group's last slot ends the group and input then stalls: the
// pipeline drains through stages B and C, a reciprocal multiply forms the common
// mode (sum / GROUP_SIZE, truncated toward zero), the group buffer is read back,
// one slot per cycle, into a two-entry output queue, and the last read settles;
// output stalls lengthen the read-back. Results flow at one per cycle while the
// output is ready. Channels at or above MODULES*GROUPS_PER_MODULE*GROUP_SIZE are
// dropped. No clearing pass runs after reset: pedestals and buffer slots must be
// written before they are used.
module pedestal_common_mode_subtract
  import pcm_pkg::*;
#(
  parameter int unsigned GROUP_SIZE        = GROUP_SIZE_DEF,
  parameter int unsigned GROUPS_PER_MODULE = GROUPS_PER_MODULE_DEF,
  parameter int unsigned MODULES           = MODULES_DEF,
  parameter int unsigned ADC_BITS          = ADC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     item_valid,
  output logic                          item_ready,
  input  wire logic                     action,
  input  wire logic [CH_W-1:0]          channel,
  input  wire logic [VAL_W-1:0]         value,
  output logic                          result_valid,
  input  wire logic                     result_ready,
  output logic [CH_W-1:0]               out_channel,
  output logic signed [OUT_W-1:0]       corrected,
  output logic                          group_last
);

  localparam int unsigned CHANNELS = MODULES * GROUPS_PER_MODULE * GROUP_SIZE;
  localparam int unsigned PED_AW   = $clog2(CHANNELS);
  localparam int unsigned POS_W    = $clog2(GROUP_SIZE);
  localparam int unsigned PROD_W   = 2 * CH_W;
  localparam int unsigned RECIP    = (2 ** CH_W) / GROUP_SIZE;

  state_t state;

  // Input transfer and pedestal table
  logic              in_xfer;
  logic              in_range;
  logic              ped_we;
  logic [VAL_W-1:0]  ped_rdata;

  assign in_xfer  = item_valid && item_ready;
  assign in_range = (32'(channel) < 32'(CHANNELS));
  assign ped_we   = in_xfer && (action == ACT_LOAD) && in_range;

  pcm_ram #(.WIDTH(VAL_W), .DEPTH(CHANNELS)) u_ped_ram (
    .clk   (clk),
    .we    (ped_we),
    .waddr (PED_AW'(channel)),
    .wdata (value),
    .raddr (PED_AW'(channel)),
    .rdata (ped_rdata)
  );

  // Stage B: pedestal arrives, slot position from reciprocal product
  logic                    b_valid;
  logic [CH_W-1:0]         b_channel;
  logic [ADC_BITS-1:0]     b_adc;
  logic [PROD_W-1:0]       b_prod;
  logic [CH_W-1:0]         b_qest;
  logic [CH_W-1:0]         b_rem;
  logic [POS_W-1:0]        b_pos;
  logic                    b_trig;
  logic signed [SUM_W-1:0] b_resid;

  always_comb begin
    b_qest  = CH_W'(b_prod >> CH_W);
    b_rem   = b_channel - CH_W'(PROD_W'(b_qest) * PROD_W'(GROUP_SIZE));
    b_pos   = (b_rem >= CH_W'(GROUP_SIZE)) ? POS_W'(b_rem - CH_W'(GROUP_SIZE))
                                           : POS_W'(b_rem);
    b_trig  = b_valid && (b_pos == POS_W'(GROUP_SIZE - 1));
    b_resid = $signed(SUM_W'({b_adc, 4'b0000})) - $signed(SUM_W'(ped_rdata));
  end

  // Stage C: buffer write and accumulate
  logic                    c_valid;
  logic                    c_trig;
  logic [POS_W-1:0]        c_pos;
  logic [ADC_BITS-1:0]     c_adc;
  logic [CH_W-1:0]         c_channel;
  logic signed [SUM_W-1:0] c_resid;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_next;
  logic                    div_start;
  logic                    div_done;
  logic signed [SUM_W-1:0] div_quot;

  assign sum_next  = sum + c_resid;
  assign div_start = c_valid && c_trig;

  pcm_div #(.DIVISOR(GROUP_SIZE), .W(SUM_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Emission side: buffer read, output queue
  logic                    issuing;
  logic                    issue;
  logic [POS_W-1:0]        k;
  logic                    pend;
  logic [POS_W-1:0]        pend_k;
  logic [ADC_BITS-1:0]     buf_rdata;
  logic signed [SUM_W-1:0] cm;
  logic [CH_W-1:0]         base;
  logic [1:0]              cnt;
  logic [1:0]              occ;
  logic                    pop;
  res_t                    e0;
  res_t                    e1;
  res_t                    new_res;
  logic signed [SUM_W:0]   diff;

  pcm_ram #(.WIDTH(ADC_BITS), .DEPTH(GROUP_SIZE)) u_buf_ram (
    .clk   (clk),
    .we    (c_valid),
    .waddr (c_pos),
    .wdata (c_adc),
    .raddr (k),
    .rdata (buf_rdata)
  );

  assign pop   = result_valid && result_ready;
  assign occ   = cnt + {1'b0, pend};
  assign issue = (state == ST_EMIT) && issuing && ((occ <= 2'd1) || (occ == 2'd2 && pop));

  // Corrected sample with saturation
  always_comb begin
    diff = $signed((SUM_W + 1)'({buf_rdata, 4'b0000})) - (SUM_W + 1)'(cm);
    new_res.channel = base + CH_W'(pend_k);
    new_res.last    = (pend_k == POS_W'(GROUP_SIZE - 1));
    if (diff < (SUM_W + 1)'(CORR_MIN)) begin
      new_res.corrected = OUT_W'(CORR_MIN);
    end else if (diff > (SUM_W + 1)'(CORR_MAX)) begin
      new_res.corrected = OUT_W'(CORR_MAX);
    end else begin
      new_res.corrected = OUT_W'(diff);
    end
  end

  // Input is held off through the end of a group
  assign item_ready = (state == ST_RUN) && !b_trig && !(c_valid && c_trig);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_RUN;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      sum     <= '0;
      issuing <= 1'b0;
      pend    <= 1'b0;
      cnt     <= '0;
    end else begin
      b_valid <= in_xfer && (action == ACT_SAMPLE) && in_range;
      c_valid <= b_valid;

      // accumulate; the group end clears the sum
      if (c_valid) begin
        sum <= c_trig ? '0 : sum_next;
      end

      pend <= issue;

      case (state)
        ST_RUN: begin
          if (div_start) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state   <= ST_EMIT;
            issuing <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (issue && (k == POS_W'(GROUP_SIZE - 1))) begin
            issuing <= 1'b0;
          end
          if (!issuing && !pend) begin
            state <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase

      // queue occupancy
      if (pend && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (!pend && pop) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    b_channel <= channel;
    b_adc     <= value[ADC_BITS-1:0];
    b_prod    <= PROD_W'(channel) * PROD_W'(RECIP);

    c_trig    <= b_trig;
    c_pos     <= b_pos;
    c_adc     <= b_adc;
    c_channel <= b_channel;
    c_resid   <= b_resid;

    if (div_start) begin
      base <= c_channel - CH_W'(GROUP_SIZE - 1);
    end
    if (div_done) begin
      cm <= div_quot;
      k  <= '0;
    end else if (issue) begin
      k <= k + 1'b1;
    end
    if (issue) begin
      pend_k <= k;
    end

    // two-entry output queue, e0 at the head
    if (pend && pop) begin
      if (cnt == 2'd2) begin
        e0 <= e1;
        e1 <= new_res;
      end else begin
        e0 <= new_res;
      end
    end else if (pend) begin
      if (cnt == 2'd0) begin
        e0 <= new_res;
      end else begin
        e1 <= new_res;
      end
    end else if (pop) begin
      e0 <= e1;
    end
  end

  assign result_valid = (cnt != 2'd0);
  assign out_channel  = e0.channel;
  assign corrected    = e0.corrected;
  assign group_last   = e0.last;

endmodule

`default_nettype wire

// File: rtl/pcm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module pcm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/pcm_div.sv
// Signed divide by a constant through reciprocal multiplication, truncating toward zero.
`default_nettype none

module pcm_div #(
  parameter int unsigned DIVISOR = 37,
  parameter int unsigned W       = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic signed [W-1:0] dividend,
  output logic                     done,
  output logic signed [W-1:0]      quotient
);

  // Reciprocal scaled so that every magnitude up to 2**(W-1) divides exactly
  localparam int unsigned     SH    = (W - 1) + $clog2(DIVISOR);
  localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [W-1:0]    MUL   = W'(RECIP);

  logic           s1;      // magnitude registered
  logic           s2;      // product registered
  logic           neg;
  logic [W-1:0]   mag;
  logic [2*W-1:0] prod;
  logic [W-1:0]   qmag;

  // Stage valid bits; done follows start through s1 and then s2
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= 1'b0;
      s2 <= 1'b0;
    end else begin
      s1 <= start;
      s2 <= s1;
    end
  end

  // Sign and magnitude, then the reciprocal product
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[W-1];
      mag <= dividend[W-1] ? W'(-dividend) : W'(dividend);
    end
    if (s1) begin
      prod <= (2*W)'(mag) * (2*W)'(MUL);
    end
  end

  assign qmag     = W'(prod >> SH);
  assign done     = s2;
  assign quotient = neg ? -$signed(qmag) : $signed(qmag);

endmodule

`default_nettype wire
